### design/pixel_format_unpacker_with_palette_top_assert.svh
// Assertion macros shared by the pixel format unpacker RTL.
`ifndef PIXEL_FORMAT_UNPACKER_WITH_PALETTE_TOP_ASSERT_SVH
`define PIXEL_FORMAT_UNPACKER_WITH_PALETTE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset
`define PFU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfu: same-cycle check failed");
// Next-cycle implication, disabled in reset
`define PFU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfu: next-cycle check failed");
`else
`define PFU_ASSERT_IMP(label, clk, rst, ante, cons)
`define PFU_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### design/pfu_pkg.sv
// Types and constants of the pixel format unpacker.
package pfu_pkg;

   // Field widths
   localparam int WORD_W = 64;
   localparam int SUB_W  = 3;
   localparam int IDX_W  = 8;
   localparam int FMT_W  = 5;
   localparam int PSZ_W  = 9;
   localparam int CH_W   = 8;
   localparam int COL_W  = 3 * CH_W;
   localparam int STEP_W = 3;

   // Palette depth default
   localparam int PALETTE_DEPTH_DEF = 256;

   // Register indexes and reset values
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = PSZ_W;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_FORMAT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_SIZE = 1'd1;
   localparam logic [FMT_W-1:0]     FMT_RESET        = 5'd3;
   localparam logic [PSZ_W-1:0]     PSZ_RESET        = 9'd0;

   // Pixel format codes; 25 to 31 are unknown and give black
   localparam logic [FMT_W-1:0] FMT_GRAY1    = 5'd0;
   localparam logic [FMT_W-1:0] FMT_GRAY2    = 5'd1;
   localparam logic [FMT_W-1:0] FMT_GRAY4    = 5'd2;
   localparam logic [FMT_W-1:0] FMT_GRAY8    = 5'd3;
   localparam logic [FMT_W-1:0] FMT_GRAY16   = 5'd4;
   localparam logic [FMT_W-1:0] FMT_GRAY32   = 5'd5;
   localparam logic [FMT_W-1:0] FMT_GRAY64   = 5'd6;
   localparam logic [FMT_W-1:0] FMT_RGB121   = 5'd7;
   localparam logic [FMT_W-1:0] FMT_BGR121   = 5'd8;
   localparam logic [FMT_W-1:0] FMT_RGB233   = 5'd9;
   localparam logic [FMT_W-1:0] FMT_BGR332   = 5'd10;
   localparam logic [FMT_W-1:0] FMT_RGB565   = 5'd11;
   localparam logic [FMT_W-1:0] FMT_BGR565   = 5'd12;
   localparam logic [FMT_W-1:0] FMT_RGB888   = 5'd13;
   localparam logic [FMT_W-1:0] FMT_BGR888   = 5'd14;
   localparam logic [FMT_W-1:0] FMT_RGBX1111 = 5'd15;
   localparam logic [FMT_W-1:0] FMT_BGRX1111 = 5'd16;
   localparam logic [FMT_W-1:0] FMT_RGBX2222 = 5'd17;
   localparam logic [FMT_W-1:0] FMT_BGRX2222 = 5'd18;
   localparam logic [FMT_W-1:0] FMT_RGBX4444 = 5'd19;
   localparam logic [FMT_W-1:0] FMT_BGRX4444 = 5'd20;
   localparam logic [FMT_W-1:0] FMT_RGBX5551 = 5'd21;
   localparam logic [FMT_W-1:0] FMT_BGRX5551 = 5'd22;
   localparam logic [FMT_W-1:0] FMT_RGBX8888 = 5'd23;
   localparam logic [FMT_W-1:0] FMT_BGRX8888 = 5'd24;

   // Item mode
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // Operation kinds issued by the sequencer
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_DIRECT = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   // Index width selection
   localparam logic [1:0] IW_1 = 2'd0;
   localparam logic [1:0] IW_2 = 2'd1;
   localparam logic [1:0] IW_4 = 2'd2;
   localparam logic [1:0] IW_8 = 2'd3;

   // One operation: a palette load, a direct decode or one palette read
   typedef struct packed {
      logic [1:0]        kind;
      logic [WORD_W-1:0] word;
      logic [SUB_W-1:0]  sub;
      logic [IDX_W-1:0]  idx;
      logic              last;
   } op_type;

   // One result word
   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            last;
   } pix_type;

endpackage

### design/pixel_format_unpacker_with_palette_top.sv
// A result passes the input hold register, stage 1, stage 2 and the output register.
// Throughput: one direct-decode or palette-load word per cycle while the skid slot is
// free; a palette word gives 8, 4, 2 or 1 reads (1/2/4/8-bit indices), one palette read
// per cycle on the RAM port. Results leave at one per cycle while rsp_stall is low,
// through an output register with a skid slot. Reset (synchronous, active high) clears
// valid state, sets pixel_format to 3, palette_size to 0; palette undefined until written.
module pixel_format_unpacker_with_palette_top #(
   parameter int PALETTE_DEPTH = pfu_pkg::PALETTE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_we,
   input  logic [pfu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pfu_pkg::CSR_W-1:0]     csr_wdata,
   // input words
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [pfu_pkg::WORD_W-1:0]    req_pixel_word,
   input  logic [pfu_pkg::SUB_W-1:0]     req_sub_index,
   input  logic [pfu_pkg::IDX_W-1:0]     req_entry_index,
   // result words
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pfu_pkg::CH_W-1:0]      rsp_red,
   output logic [pfu_pkg::CH_W-1:0]      rsp_green,
   output logic [pfu_pkg::CH_W-1:0]      rsp_blue,
   output logic                          rsp_last
);
   import pfu_pkg::*;

   logic [FMT_W-1:0] pixel_format_ff;
   logic [PSZ_W-1:0] palette_size_ff;
   logic             advance;
   logic             op_valid;
   op_type           op;
   logic             pix_valid;
   pix_type          pix;
   pix_type          rsp_pix;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= FMT_RESET;
         palette_size_ff <= PSZ_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PIXEL_FORMAT: pixel_format_ff <= csr_wdata[FMT_W-1:0];
            CSR_PALETTE_SIZE: palette_size_ff <= csr_wdata[PSZ_W-1:0];
            default: ;
         endcase
      end
   end

   pfu_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .palette_size    (palette_size_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_pixel_word  (req_pixel_word),
      .req_sub_index   (req_sub_index),
      .req_entry_index (req_entry_index),
      .op_valid        (op_valid),
      .op              (op)
   );

   pfu_dec #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_dec (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .pixel_format (pixel_format_ff),
      .op_valid     (op_valid),
      .op           (op),
      .pix_valid    (pix_valid),
      .pix          (pix)
   );

   // whole pipeline moves while the skid slot is free
   pfu_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pix_valid),
      .in_pix    (pix),
      .ready     (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_pix   (rsp_pix)
   );

   assign rsp_red   = rsp_pix.red;
   assign rsp_green = rsp_pix.green;
   assign rsp_blue  = rsp_pix.blue;
   assign rsp_last  = rsp_pix.last;

endmodule

### design/pfu_ram.sv
// Generic single-port RAM with registered read.
module pfu_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or read one entry per cycle
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

### design/pfu_seq.sv
// Input stage: holds one word and issues one operation per cycle while advance is high.
module pfu_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [pfu_pkg::PSZ_W-1:0]    palette_size,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_mode,
   input  logic [pfu_pkg::WORD_W-1:0]   req_pixel_word,
   input  logic [pfu_pkg::SUB_W-1:0]    req_sub_index,
   input  logic [pfu_pkg::IDX_W-1:0]    req_entry_index,
   output logic                         op_valid,
   output pfu_pkg::op_type              op
);
   import pfu_pkg::*;

   logic              s0_valid_ff, s0_valid_in;
   logic              s0_mode_ff;
   logic [WORD_W-1:0] s0_word_ff;
   logic [SUB_W-1:0]  s0_sub_ff;
   logic [IDX_W-1:0]  s0_entry_ff;
   logic [STEP_W-1:0] s0_step_ff, s0_step_in;

   logic              accept;
   logic              is_pal;
   logic              step_last;
   logic              free;
   logic [1:0]        iw_sel;
   logic [IDX_W-1:0]  byte0;
   logic [IDX_W-1:0]  pal_idx;

   assign byte0  = s0_word_ff[IDX_W-1:0];
   assign is_pal = (s0_mode_ff == MODE_DECODE) && (palette_size != '0);

   // index width from palette size
   always_comb begin
      if (palette_size <= PSZ_W'(2)) begin
         iw_sel = IW_1;
      end else if (palette_size <= PSZ_W'(4)) begin
         iw_sel = IW_2;
      end else if (palette_size <= PSZ_W'(16)) begin
         iw_sel = IW_4;
      end else begin
         iw_sel = IW_8;
      end
   end

   // pick the index for this step, low bits first
   always_comb begin
      unique case (iw_sel)
         IW_1: begin
            pal_idx   = {{(IDX_W-1){1'b0}}, byte0[s0_step_ff]};
            step_last = (s0_step_ff == 3'd7);
         end
         IW_2: begin
            pal_idx   = {{(IDX_W-2){1'b0}}, byte0[{s0_step_ff[1:0], 1'b0} +: 2]};
            step_last = (s0_step_ff[1:0] == 2'd3);
         end
         IW_4: begin
            pal_idx   = {{(IDX_W-4){1'b0}}, byte0[{s0_step_ff[0], 2'b00} +: 4]};
            step_last = s0_step_ff[0];
         end
         default: begin
            pal_idx   = byte0;
            step_last = 1'b1;
         end
      endcase
   end

   // operation towards the decode stage
   always_comb begin
      op.word = s0_word_ff;
      op.sub  = s0_sub_ff;
      if (s0_mode_ff == MODE_LOAD) begin
         op.kind = OP_LOAD;
         op.idx  = s0_entry_ff;
         op.last = 1'b1;
      end else if (!is_pal) begin
         op.kind = OP_DIRECT;
         op.idx  = s0_entry_ff;
         op.last = 1'b1;
      end else begin
         op.kind = OP_LOOKUP;
         op.idx  = pal_idx;
         op.last = step_last;
      end
   end

   assign op_valid  = s0_valid_ff;
   assign free      = advance && (!is_pal || step_last);
   assign req_stall = s0_valid_ff && !free;
   assign accept    = req_valid && !req_stall;

   // word hold and step count
   always_comb begin
      s0_valid_in = s0_valid_ff;
      s0_step_in  = s0_step_ff;
      if (accept) begin
         s0_valid_in = 1'b1;
         s0_step_in  = '0;
      end else if (s0_valid_ff && free) begin
         s0_valid_in = 1'b0;
      end else if (s0_valid_ff && advance) begin
         s0_step_in  = s0_step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s0_step_ff  <= '0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s0_step_ff  <= s0_step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_mode_ff  <= req_mode;
         s0_word_ff  <= req_pixel_word;
         s0_sub_ff   <= req_sub_index;
         s0_entry_ff <= req_entry_index;
      end
   end

endmodule

### design/pfu_dec.sv
// Decode and palette stages: format decode, palette write and read.
module pfu_dec #(
   parameter int PALETTE_DEPTH = pfu_pkg::PALETTE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [pfu_pkg::FMT_W-1:0] pixel_format,
   input  logic                      op_valid,
   input  pfu_pkg::op_type           op,
   output logic                      pix_valid,
   output pfu_pkg::pix_type          pix
);
   import pfu_pkg::*;

   localparam int AW = $clog2(PALETTE_DEPTH);

   // bit replication helpers
   function automatic logic [CH_W-1:0] rep1(input logic v);
      return {CH_W{v}};
   endfunction
   function automatic logic [CH_W-1:0] rep2(input logic [1:0] v);
      return {4{v}};
   endfunction
   function automatic logic [CH_W-1:0] rep3(input logic [2:0] v);
      return {v, v, v[2:1]};
   endfunction
   function automatic logic [CH_W-1:0] rep4(input logic [3:0] v);
      return {v, v};
   endfunction
   function automatic logic [CH_W-1:0] rep5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction
   function automatic logic [CH_W-1:0] rep6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   // stage 1
   logic   s1_valid_ff;
   op_type s1_op_ff;

   // stage 2
   logic             s2_valid_ff;
   logic [1:0]       s2_kind_ff;
   logic             s2_last_ff;
   logic             s2_oob_ff;
   logic [COL_W-1:0] s2_col_ff;

   logic [CH_W-1:0]  b0, by1, by2;
   logic [15:0]      h;
   logic [3:0]       nib;
   logic [CH_W-1:0]  r, g, b;
   logic [COL_W-1:0] dec_col;
   logic             oob;
   logic             ram_en, ram_we;
   logic [COL_W-1:0] ram_q;
   logic [COL_W-1:0] out_col;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= op_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff <= op;
      end
   end

   // format decode
   assign b0  = s1_op_ff.word[7:0];
   assign by1 = s1_op_ff.word[15:8];
   assign by2 = s1_op_ff.word[23:16];
   assign h   = s1_op_ff.word[15:0];
   assign nib = s1_op_ff.sub[0] ? b0[7:4] : b0[3:0];

   always_comb begin
      r = '0;
      g = '0;
      b = '0;
      unique case (pixel_format)
         FMT_GRAY1: begin
            r = rep1(b0[s1_op_ff.sub]); g = r; b = r;
         end
         FMT_GRAY2: begin
            r = rep2(b0[{s1_op_ff.sub[1:0], 1'b0} +: 2]); g = r; b = r;
         end
         FMT_GRAY4: begin
            r = rep4(nib); g = r; b = r;
         end
         FMT_GRAY8: begin
            r = b0; g = b0; b = b0;
         end
         FMT_GRAY16: begin
            r = by1; g = by1; b = by1;
         end
         FMT_GRAY32: begin
            r = s1_op_ff.word[31:24]; g = r; b = r;
         end
         FMT_GRAY64: begin
            r = s1_op_ff.word[63:56]; g = r; b = r;
         end
         FMT_RGB121: begin
            r = rep1(nib[0]); g = rep2(nib[2:1]); b = rep1(nib[3]);
         end
         FMT_BGR121: begin
            r = rep1(nib[3]); g = rep2(nib[2:1]); b = rep1(nib[0]);
         end
         FMT_RGB233: begin
            r = rep2(b0[1:0]); g = rep3(b0[4:2]); b = rep3(b0[7:5]);
         end
         FMT_BGR332: begin
            r = rep3(b0[2:0]); g = rep3(b0[5:3]); b = rep2(b0[7:6]);
         end
         FMT_RGB565: begin
            r = rep5(h[4:0]); g = rep6(h[10:5]); b = rep5(h[15:11]);
         end
         FMT_BGR565: begin
            r = rep5(h[15:11]); g = rep6(h[10:5]); b = rep5(h[4:0]);
         end
         FMT_RGB888, FMT_RGBX8888: begin
            r = b0; g = by1; b = by2;
         end
         FMT_BGR888, FMT_BGRX8888: begin
            r = by2; g = by1; b = b0;
         end
         FMT_RGBX1111: begin
            r = rep1(nib[0]); g = rep1(nib[1]); b = rep1(nib[2]);
         end
         FMT_BGRX1111: begin
            r = rep1(nib[2]); g = rep1(nib[1]); b = rep1(nib[0]);
         end
         FMT_RGBX2222: begin
            r = rep2(b0[1:0]); g = rep2(b0[3:2]); b = rep2(b0[5:4]);
         end
         FMT_BGRX2222: begin
            r = rep2(b0[5:4]); g = rep2(b0[3:2]); b = rep2(b0[1:0]);
         end
         FMT_RGBX4444: begin
            r = rep4(h[3:0]); g = rep4(h[7:4]); b = rep4(h[11:8]);
         end
         FMT_BGRX4444: begin
            r = rep4(h[11:8]); g = rep4(h[7:4]); b = rep4(h[3:0]);
         end
         FMT_RGBX5551: begin
            r = rep5(h[4:0]); g = rep5(h[9:5]); b = rep5(h[14:10]);
         end
         FMT_BGRX5551: begin
            r = rep5(h[14:10]); g = rep5(h[9:5]); b = rep5(h[4:0]);
         end
         default: begin
            r = '0; g = '0; b = '0;
         end
      endcase
   end

   assign dec_col = {r, g, b};

   // palette access; slots past the store are dropped on load, black on read
   assign oob    = ({1'b0, s1_op_ff.idx} >= (IDX_W+1)'(PALETTE_DEPTH));
   assign ram_we = (s1_op_ff.kind == OP_LOAD);
   assign ram_en = advance && s1_valid_ff && !oob &&
                   ((s1_op_ff.kind == OP_LOAD) || (s1_op_ff.kind == OP_LOOKUP));

   pfu_ram #(
      .WIDTH (COL_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (s1_op_ff.idx[AW-1:0]),
      .wdata (dec_col),
      .rdata (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_kind_ff <= s1_op_ff.kind;
         s2_last_ff <= s1_op_ff.last;
         s2_oob_ff  <= oob;
         s2_col_ff  <= dec_col;
      end
   end

   // result select; loads leave no result
   always_comb begin
      if (s2_kind_ff == OP_LOOKUP) begin
         out_col = s2_oob_ff ? '0 : ram_q;
      end else begin
         out_col = s2_col_ff;
      end
   end

   assign pix_valid = s2_valid_ff && (s2_kind_ff != OP_LOAD);
   assign pix.red   = out_col[COL_W-1 -: CH_W];
   assign pix.green = out_col[CH_W +: CH_W];
   assign pix.blue  = out_col[CH_W-1:0];
   assign pix.last  = s2_last_ff;

endmodule

### design/pfu_skid.sv
// Output register with skid slot.
`include "pixel_format_unpacker_with_palette_top_assert.svh"
module pfu_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  pfu_pkg::pix_type in_pix,
   output logic             ready,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pfu_pkg::pix_type rsp_pix
);
   import pfu_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   pix_type rsp_pix_ff, rsp_pix_in;
   pix_type skid_pix_ff, skid_pix_in;
   logic    take, push;

   assign ready = !skid_valid_ff;
   assign take  = rsp_valid_ff && !rsp_stall;
   assign push  = in_valid && ready;

   // output and skid update
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_pix_in    = rsp_pix_ff;
      skid_pix_in   = skid_pix_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_pix_in    = skid_pix_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff || take) begin
            rsp_pix_in   = in_pix;
            rsp_valid_in = 1'b1;
         end else begin
            skid_pix_in   = in_pix;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pix_ff  <= rsp_pix_in;
      skid_pix_ff <= skid_pix_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pix   = rsp_pix_ff;

   // skid holds a word only behind a full output register
   `PFU_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   // a stalled result is never dropped
   `PFU_ASSERT_NXT(a_out_kept, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff)
   // a parked word stays while the output is stalled
   `PFU_ASSERT_NXT(a_skid_kept, clock, reset, skid_valid_ff && rsp_stall, skid_valid_ff)

endmodule

### tb/testbench.sv
// Self-checking testbench for the pixel format unpacker with palette expansion.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pfu_pkg::*;

   localparam logic [FMT_W-1:0] FMT_UNKNOWN_LAST = 5'd31;
   localparam logic [FMT_W-1:0] FMT_RANDOM_TOP   = 5'd27;

   localparam int PHASES          = 13;
   localparam int ITEMS_PER_PHASE = 20;
   localparam int HOLD_PHASE      = 2;     // one-bit indices: eight results per word
   localparam int LONG_HOLD       = 240;
   localparam int SETTLE_CYCLES   = 8;     // lets the pipeline empty; loads leave no trace
   localparam int TAIL_CYCLES     = 16;
   localparam int STALL_LIMIT     = 3000;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_mode;
   logic [WORD_W-1:0]    req_pixel_word;
   logic [SUB_W-1:0]     req_sub_index;
   logic [IDX_W-1:0]     req_entry_index;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [CH_W-1:0]      rsp_red;
   logic [CH_W-1:0]      rsp_green;
   logic [CH_W-1:0]      rsp_blue;
   logic                 rsp_last;

   pixel_format_unpacker_with_palette_top dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_pixel_word  (req_pixel_word),
      .req_sub_index   (req_sub_index),
      .req_entry_index (req_entry_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_last        (rsp_last)
   );

   // One directed stimulus row; colour is used only where typed is set
   typedef struct {
      logic [FMT_W-1:0]  fmt;
      logic [PSZ_W-1:0]  psize;
      logic              mode;
      logic [WORD_W-1:0] word;
      logic [SUB_W-1:0]  sub;
      logic [IDX_W-1:0]  slot;
      bit                typed;
      logic [COL_W-1:0]  colour;
   } probe_row_type;

   probe_row_type    probe_rows[$];
   pix_type          expected_pixels[$];
   logic [COL_W-1:0] palette_shadow[256];
   bit               entry_written[256];
   logic [FMT_W-1:0] fmt_shadow;
   logic [PSZ_W-1:0] psize_shadow;

   int phase_psize[PHASES] = '{0, 256, 1, 511, 0, 3, 16, 0, 17, 4, 2, 5, 0};

   int mismatches;
   int words_sent;
   int loads_sent;
   int results_seen;
   int settings_used;
   int holds_asked;
   int holds_granted;
   int quiet_cycles;

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Bit replication of narrow channels up to eight bits
   function automatic logic [7:0] widen1(logic [15:0] v);
      return {8{v[0]}};
   endfunction

   function automatic logic [7:0] widen2(logic [15:0] v);
      return {4{v[1:0]}};
   endfunction

   function automatic logic [7:0] widen3(logic [15:0] v);
      return {v[2:0], v[2:0], v[2:1]};
   endfunction

   function automatic logic [7:0] widen4(logic [15:0] v);
      return {2{v[3:0]}};
   endfunction

   function automatic logic [7:0] widen5(logic [15:0] v);
      return {v[4:0], v[4:2]};
   endfunction

   function automatic logic [7:0] widen6(logic [15:0] v);
      return {v[5:0], v[5:4]};
   endfunction

   // Colour of one stored pixel under a given format
   function automatic logic [COL_W-1:0] unpack_pixel(logic [WORD_W-1:0] w,
                                                     logic [SUB_W-1:0] sub,
                                                     logic [FMT_W-1:0] fmt);
      logic [15:0] b0;
      logic [15:0] h;
      logic [15:0] nib;
      logic [7:0]  r, g, b;
      b0  = 16'(w[7:0]);
      h   = w[15:0];
      nib = 16'(sub[0] ? w[7:4] : w[3:0]);
      r   = '0;
      g   = '0;
      b   = '0;
      case (fmt)
         FMT_GRAY1: begin
            r = widen1(b0 >> sub); g = r; b = r;
         end
         FMT_GRAY2: begin
            r = widen2(b0 >> {sub[1:0], 1'b0}); g = r; b = r;
         end
         FMT_GRAY4: begin
            r = widen4(nib); g = r; b = r;
         end
         FMT_GRAY8: begin
            r = w[7:0]; g = r; b = r;
         end
         FMT_GRAY16: begin
            r = w[15:8]; g = r; b = r;
         end
         FMT_GRAY32: begin
            r = w[31:24]; g = r; b = r;
         end
         FMT_GRAY64: begin
            r = w[63:56]; g = r; b = r;
         end
         FMT_RGB121: begin
            r = widen1(nib); g = widen2(nib >> 1); b = widen1(nib >> 3);
         end
         FMT_BGR121: begin
            r = widen1(nib >> 3); g = widen2(nib >> 1); b = widen1(nib);
         end
         FMT_RGB233: begin
            r = widen2(b0); g = widen3(b0 >> 2); b = widen3(b0 >> 5);
         end
         FMT_BGR332: begin
            r = widen3(b0); g = widen3(b0 >> 3); b = widen2(b0 >> 6);
         end
         FMT_RGB565: begin
            r = widen5(h); g = widen6(h >> 5); b = widen5(h >> 11);
         end
         FMT_BGR565: begin
            r = widen5(h >> 11); g = widen6(h >> 5); b = widen5(h);
         end
         FMT_RGB888, FMT_RGBX8888: begin
            r = w[7:0]; g = w[15:8]; b = w[23:16];
         end
         FMT_BGR888, FMT_BGRX8888: begin
            r = w[23:16]; g = w[15:8]; b = w[7:0];
         end
         FMT_RGBX1111: begin
            r = widen1(nib); g = widen1(nib >> 1); b = widen1(nib >> 2);
         end
         FMT_BGRX1111: begin
            r = widen1(nib >> 2); g = widen1(nib >> 1); b = widen1(nib);
         end
         FMT_RGBX2222: begin
            r = widen2(b0); g = widen2(b0 >> 2); b = widen2(b0 >> 4);
         end
         FMT_BGRX2222: begin
            r = widen2(b0 >> 4); g = widen2(b0 >> 2); b = widen2(b0);
         end
         FMT_RGBX4444: begin
            r = widen4(h); g = widen4(h >> 4); b = widen4(h >> 8);
         end
         FMT_BGRX4444: begin
            r = widen4(h >> 8); g = widen4(h >> 4); b = widen4(h);
         end
         FMT_RGBX5551: begin
            r = widen5(h); g = widen5(h >> 5); b = widen5(h >> 10);
         end
         FMT_BGRX5551: begin
            r = widen5(h >> 10); g = widen5(h >> 5); b = widen5(h);
         end
         default: ;
      endcase
      return {r, g, b};
   endfunction

   // Index width for a palette size; anything above 16 uses whole bytes
   function automatic int index_bits(logic [PSZ_W-1:0] psz);
      if (psz <= 2)
         return 1;
      else if (psz <= 4)
         return 2;
      else if (psz <= 16)
         return 4;
      return 8;
   endfunction

   // Index byte whose every field points at a palette entry already loaded
   function automatic logic [7:0] pick_index_byte(int bits);
      logic [7:0] ib;
      int         span;
      int         start;
      int         e;
      ib   = '0;
      span = 1 << bits;
      for (int i = 0; i < 8 / bits; i++) begin
         start = $urandom_range(0, span - 1);
         e     = 0;
         for (int t = 0; t < span; t++) begin
            if (entry_written[(start + t) % span]) begin
               e = (start + t) % span;
               break;
            end
         end
         ib = ib | (8'(e) << (i * bits));
      end
      return ib;
   endfunction

   // Expected results of one accepted word; loads update the palette copy
   task automatic predict_pixels(logic mode, logic [WORD_W-1:0] w,
                                 logic [SUB_W-1:0] sub, logic [IDX_W-1:0] slot);
      int         bits;
      int         count;
      logic [7:0] idx;
      if (mode == MODE_LOAD) begin
         palette_shadow[slot] = unpack_pixel(w, sub, fmt_shadow);
         entry_written[slot]  = 1'b1;
         loads_sent++;
      end else if (psize_shadow == 0) begin
         expected_pixels.push_back({unpack_pixel(w, sub, fmt_shadow), 1'b1});
      end else begin
         bits  = index_bits(psize_shadow);
         count = 8 / bits;
         for (int i = 0; i < count; i++) begin
            idx = (w[7:0] >> (i * bits)) & 8'((1 << bits) - 1);
            expected_pixels.push_back({palette_shadow[idx], i == count - 1});
         end
      end
   endtask

   // Offer one word after a random gap (none when quiet) and hold it until taken
   task automatic push_pixel_word(logic mode, logic [WORD_W-1:0] w, logic [SUB_W-1:0] sub,
                                  logic [IDX_W-1:0] slot, bit quiet);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_pixel_word  <= w;
      req_sub_index   <= sub;
      req_entry_index <= slot;
      do @(posedge clock); while (req_stall !== 1'b0);
      words_sent++;
   endtask

   // Stop offering and let every outstanding result and load drain
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers written back to back on an idle block
   task automatic apply_settings(logic [FMT_W-1:0] fmt, logic [PSZ_W-1:0] psz);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_PIXEL_FORMAT;
      csr_wdata <= CSR_W'(fmt);
      @(posedge clock);
      csr_index <= CSR_PALETTE_SIZE;
      csr_wdata <= psz;
      @(posedge clock);
      csr_we       <= 1'b0;
      fmt_shadow   = fmt;
      psize_shadow = psz;
      settings_used++;
   endtask

   task automatic add_probe(logic [FMT_W-1:0] fmt, logic [PSZ_W-1:0] psz, logic mode,
                            logic [WORD_W-1:0] w, logic [SUB_W-1:0] sub,
                            logic [IDX_W-1:0] slot, bit typed, logic [COL_W-1:0] colour);
      probe_row_type row;
      row.fmt    = fmt;
      row.psize  = psz;
      row.mode   = mode;
      row.word   = w;
      row.sub    = sub;
      row.slot   = slot;
      row.typed  = typed;
      row.colour = colour;
      probe_rows.push_back(row);
   endtask

   task automatic flag_mismatch(string what, pix_type want, pix_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: want %02h %02h %02h last %0b, got %02h %02h %02h last %0b",
                  $realtime, what, want.red, want.green, want.blue, want.last,
                  got.red, got.green, got.blue, got.last);
   endtask

   // Result checker: every accepted word against the oldest expectation
   always @(posedge clock) begin : result_check
      pix_type got;
      pix_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = {rsp_red, rsp_green, rsp_blue, rsp_last};
         results_seen++;
         if (expected_pixels.size() == 0) begin
            flag_mismatch("result word with nothing expected", '0, got);
         end else begin
            want = expected_pixels.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.last !== want.last)
               flag_mismatch("result word differs", want, got);
         end
      end
   end

   // Watchdog on cycles in which neither side moves a word
   always @(posedge clock) begin : watchdog
      if (reset === 1'b1 || (req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, expected_pixels.size());
         $display("testbench failed");
         $finish;
      end
   end

   // Result side: random stall before each word, quiet stretches, one long hold-off
   initial begin : receiver
      int hold;
      int taken;
      bit sink_quiet;
      taken      = 0;
      sink_quiet = 1'b0;
      forever begin
         hold = sink_quiet ? 0 : $urandom_range(0, 17);
         if (holds_granted != holds_asked) begin
            hold = LONG_HOLD;
            holds_granted++;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1 || reset !== 1'b0);
         taken++;
         if (taken % 32 == 0)
            sink_quiet = ($urandom_range(0, 3) == 0);
      end
   end

   // Stimulus: directed rows, then random phases under changing settings
   initial begin : stimulus
      logic [FMT_W-1:0]  fmt;
      logic [WORD_W-1:0] w;
      logic              mode;
      logic [SUB_W-1:0]  sub;
      logic [IDX_W-1:0]  slot;
      bit                src_quiet;
      int                pick;

      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= CSR_PIXEL_FORMAT;
      csr_wdata       <= '0;
      req_valid       <= 1'b0;
      req_mode        <= MODE_DECODE;
      req_pixel_word  <= '0;
      req_sub_index   <= '0;
      req_entry_index <= '0;
      fmt_shadow      = FMT_RESET;
      psize_shadow    = PSZ_RESET;

      // Reset settings first: gray8, direct decode
      add_probe(FMT_GRAY8, 9'd0, MODE_DECODE, '0, 3'd0, 8'd0, 1'b1, 24'h000000);
      add_probe(FMT_GRAY8, 9'd0, MODE_DECODE, '1, 3'd7, 8'd255, 1'b1, 24'hFFFFFF);
      // Sub-byte and wider grays; surplus sub-index bits are ignored
      add_probe(FMT_GRAY1, 9'd0, MODE_DECODE, 64'h80, 3'd7, 8'd0, 1'b1, 24'hFFFFFF);
      add_probe(FMT_GRAY2, 9'd0, MODE_DECODE, 64'h40, 3'd7, 8'd0, 1'b1, 24'h555555);
      add_probe(FMT_GRAY4, 9'd0, MODE_DECODE, 64'hA5, 3'd6, 8'd0, 1'b1, 24'h555555);
      add_probe(FMT_GRAY16, 9'd0, MODE_DECODE, 64'hC300, 3'd0, 8'd0, 1'b1, 24'hC3C3C3);
      add_probe(FMT_GRAY32, 9'd0, MODE_DECODE, 64'h7E00_0000, 3'd3, 8'd0, 1'b0, '0);
      add_probe(FMT_GRAY64, 9'd0, MODE_DECODE, 64'hFF00_0000_0000_0000, 3'd0, 8'd0,
                1'b1, 24'hFFFFFF);
      // Colour formats, BGR swaps included
      add_probe(FMT_RGB121, 9'd0, MODE_DECODE, 64'hD6, 3'd1, 8'd0, 1'b0, '0);
      add_probe(FMT_RGB233, 9'd0, MODE_DECODE, 64'hB4, 3'd0, 8'd0, 1'b0, '0);
      add_probe(FMT_BGR332, 9'd0, MODE_DECODE, 64'h4B, 3'd0, 8'd0, 1'b0, '0);
      add_probe(FMT_RGB565, 9'd0, MODE_DECODE, 64'h07E0, 3'd0, 8'd0, 1'b1, 24'h00FF00);
      add_probe(FMT_BGR565, 9'd0, MODE_DECODE, 64'hF81F, 3'd0, 8'd0, 1'b0, '0);
      add_probe(FMT_RGB888, 9'd0, MODE_DECODE, 64'h33_2211, 3'd0, 8'd0, 1'b1, 24'h112233);
      add_probe(FMT_BGRX8888, 9'd0, MODE_DECODE, 64'hFFFF_FFFF_FF33_2211, 3'd0, 8'd0,
                1'b1, 24'h332211);
      add_probe(FMT_BGRX1111, 9'd0, MODE_DECODE, 64'h40, 3'd1, 8'd0, 1'b0, '0);
      add_probe(FMT_RGBX4444, 9'd0, MODE_DECODE, 64'hF0A5, 3'd0, 8'd0, 1'b0, '0);
      add_probe(FMT_BGRX5551, 9'd0, MODE_DECODE, 64'h7C01, 3'd0, 8'd0, 1'b0, '0);
      // Unknown format code gives black
      add_probe(FMT_UNKNOWN_LAST, 9'd0, MODE_DECODE, '1, 3'd7, 8'd0, 1'b1, 24'h000000);
      // Palette loads: no result words
      add_probe(FMT_RGB888, 9'd0, MODE_LOAD, 64'h30_2010, 3'd0, 8'd0, 1'b0, '0);
      add_probe(FMT_RGB888, 9'd0, MODE_LOAD, 64'hC0_B0A0, 3'd0, 8'd1, 1'b0, '0);
      add_probe(FMT_RGB888, 9'd0, MODE_LOAD, '1, 3'd0, 8'd255, 1'b0, '0);
      // Size 1: index 1 lies past the size but inside the store
      add_probe(FMT_RGB888, 9'd1, MODE_DECODE, 64'hA5, 3'd0, 8'd0, 1'b0, '0);
      add_probe(FMT_RGB888, 9'd256, MODE_DECODE, 64'hFF, 3'd0, 8'd0, 1'b0, '0);
      // Size above 256 behaves as 256
      add_probe(FMT_RGB888, 9'd511, MODE_DECODE, 64'h01, 3'd0, 8'd0, 1'b0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_rows[i]) begin
         if (probe_rows[i].fmt != fmt_shadow || probe_rows[i].psize != psize_shadow)
            apply_settings(probe_rows[i].fmt, probe_rows[i].psize);
         push_pixel_word(probe_rows[i].mode, probe_rows[i].word, probe_rows[i].sub,
                         probe_rows[i].slot, 1'b0);
         if (probe_rows[i].typed)
            expected_pixels.push_back({probe_rows[i].colour, 1'b1});
         else
            predict_pixels(probe_rows[i].mode, probe_rows[i].word, probe_rows[i].sub,
                           probe_rows[i].slot);
      end

      // Random phases; each starts from an idle block with new settings
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 0)
            fmt = FMT_GRAY1;
         else if (ph == 1)
            fmt = FMT_UNKNOWN_LAST;
         else
            fmt = FMT_W'($urandom_range(0, FMT_RANDOM_TOP));
         apply_settings(fmt, PSZ_W'(phase_psize[ph]));
         src_quiet = (ph == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
         if (ph == HOLD_PHASE)
            holds_asked++;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 15);
            w    = {$urandom, $urandom};
            if (pick == 0)
               w = '0;
            else if (pick == 1)
               w = '1;
            mode = (pick >= 11) ? MODE_LOAD : MODE_DECODE;
            sub  = SUB_W'($urandom_range(0, 7));
            slot = IDX_W'($urandom_range(0, 255));
            // palette decodes only name entries that hold a colour
            if (mode == MODE_DECODE && psize_shadow != 0)
               w[7:0] = pick_index_byte(index_bits(psize_shadow));
            push_pixel_word(mode, w, sub, slot, src_quiet);
            predict_pixels(mode, w, sub, slot);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d input words (%0d palette loads) under %0d register settings,",
               words_sent, loads_sent, settings_used);
      $display("with a %0d-cycle output hold-off; %0d result words checked, %0d mismatches.",
               LONG_HOLD, results_seen, mismatches);
      if (mismatches == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

### pixel_format_unpacker_with_palette_top.f
+incdir+design
design/pfu_pkg.sv
design/pfu_ram.sv
design/pfu_seq.sv
design/pfu_dec.sv
design/pfu_skid.sv
design/pixel_format_unpacker_with_palette_top.sv
tb/testbench.sv
